// ----- rtl/tst_pkg.sv -----
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants
// Field widths, error codes and the command and result records that pass
// between the front end, the queues and the back end.
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam int MAX_FEATURES_DEF = 64;
    localparam int MAX_SUBJECTS_DEF = 256;
    localparam int CMD_QUEUE_LOG2   = 2;
    localparam int RES_QUEUE_LOG2   = 1;

    localparam int FC_W   = 7;
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 24;
    localparam int CNT_W  = 9;
    localparam int SUM_W  = 32;
    localparam int SQ_W   = 56;
    localparam int STAT_W = 32;
    localparam int ERR_W  = 2;

    localparam logic [FC_W-1:0] FC_RESET = 7'd64;

    localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FEW  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ZERO = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVF  = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]        pos;
        logic                    grp;
        logic signed [VAL_W-1:0] value;
        logic                    do_acc;
        logic                    is_end;
        logic [CNT_W-1:0]        na;
        logic [CNT_W-1:0]        nb;
        logic                    ovf;
        logic [FC_W-1:0]         fc;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  feature_index;
        logic [STAT_W-1:0] statistic;
        logic [ERR_W-1:0]  error_code;
        logic              last_feature;
    } res_t;

endpackage

// ----- rtl/tst_fifo.sv -----
// ----------------------------------------------------------------------------
// tst_fifo: short register queue
// First-in first-out store with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module tst_fifo #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] data_in,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] data_out,
    output logic             empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      slot_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg;
    logic [DEPTH_LOG2-1:0] rd_ptr_reg;
    logic [DEPTH_LOG2:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == (DEPTH_LOG2+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/tst_front.sv -----
// ----------------------------------------------------------------------------
// tst_front: item intake and classification
// Tracks feature position, subject counts and overflow, and turns each item
// into one command for the back end.
// ----------------------------------------------------------------------------
module tst_front #(
    parameter int MAX_FEATURES = tst_pkg::MAX_FEATURES_DEF,
    parameter int MAX_SUBJECTS = tst_pkg::MAX_SUBJECTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tst_pkg::FC_W-1:0]        cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            group,
    input  logic signed [tst_pkg::VAL_W-1:0] value,
    input  logic                            end_of_data,
    output logic                            cmd_push,
    input  logic                            cmd_full,
    output tst_pkg::cmd_t                   cmd
);

    localparam logic [tst_pkg::FC_W-1:0] MAXF = tst_pkg::FC_W'(MAX_FEATURES);

    logic [tst_pkg::FC_W-1:0]  fc_reg;
    logic [tst_pkg::IDX_W-1:0] pos_reg;
    logic [tst_pkg::CNT_W-1:0] na_reg;
    logic [tst_pkg::CNT_W-1:0] nb_reg;
    logic                      ovf_reg;

    logic [tst_pkg::FC_W-1:0]  fc_eff;
    logic [tst_pkg::IDX_W-1:0] pos_cur;
    logic [tst_pkg::FC_W-1:0]  pos_inc;
    logic [tst_pkg::IDX_W-1:0] pos_next;
    logic [tst_pkg::CNT_W:0]   total;
    logic                      start;
    logic                      ovf_next;
    logic [tst_pkg::CNT_W-1:0] na_next;
    logic [tst_pkg::CNT_W-1:0] nb_next;
    logic                      accept;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;
    assign accept    = push && !cmd_full;
    assign cmd_push  = accept;

    always_comb
    begin
        if (fc_reg == '0)
        begin
            fc_eff = tst_pkg::FC_W'(1);
        end
        else if (fc_reg > MAXF)
        begin
            fc_eff = MAXF;
        end
        else
        begin
            fc_eff = fc_reg;
        end
        pos_cur  = ({1'b0, pos_reg} >= fc_eff) ? '0 : pos_reg;
        start    = (pos_cur == '0);
        total    = {1'b0, na_reg} + {1'b0, nb_reg};
        ovf_next = ovf_reg || (start && (total >= (tst_pkg::CNT_W+1)'(MAX_SUBJECTS)));
        na_next  = na_reg + tst_pkg::CNT_W'(start && !ovf_next && !group);
        nb_next  = nb_reg + tst_pkg::CNT_W'(start && !ovf_next && group);
        pos_inc  = {1'b0, pos_cur} + 1'b1;
        pos_next = (pos_inc >= fc_eff) ? '0 : pos_inc[tst_pkg::IDX_W-1:0];

        cmd.pos    = pos_cur;
        cmd.grp    = group;
        cmd.value  = value;
        cmd.do_acc = !ovf_next;
        cmd.is_end = end_of_data;
        cmd.na     = na_next;
        cmd.nb     = nb_next;
        cmd.ovf    = ovf_next;
        cmd.fc     = fc_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg  <= tst_pkg::FC_RESET;
            pos_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                fc_reg <= cfg_data;
            end
            if (accept)
            begin
                if (end_of_data)
                begin
                    pos_reg <= '0;
                    na_reg  <= '0;
                    nb_reg  <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_next;
                    na_reg  <= na_next;
                    nb_reg  <= nb_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

endmodule

// ----- rtl/tst_back.sv -----
// ----------------------------------------------------------------------------
// tst_back: accumulation and statistic evaluation
// Holds per-feature sums, runs read-modify-write accumulation, and evaluates
// each feature with a shift-add multiplier, restoring divider and root.
// ----------------------------------------------------------------------------
module tst_back #(
    parameter int MAX_FEATURES = tst_pkg::MAX_FEATURES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  tst_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          res_full,
    output logic          res_push,
    output tst_pkg::res_t res
);

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_ACC_RD, S_ACC_WR, S_EV_START, S_EV_RD, S_EV_LOAD,
        S_MUL_LOAD, S_MUL_RUN, S_MUL_DONE, S_DIV, S_SQRT_INIT, S_SQRT, S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NAQA, OP_SASQ, OP_NBQB, OP_SBSQ, OP_TAN, OP_TBN,
        OP_SANB, OP_SBNA, OP_DSQ, OP_DN
    } op_t;

    state_t state_reg;
    op_t    op_reg;
    tst_pkg::cmd_t cmd_reg;

    logic signed [tst_pkg::SUM_W-1:0] mem_sa [MAX_FEATURES];
    logic signed [tst_pkg::SUM_W-1:0] mem_sb [MAX_FEATURES];
    logic [tst_pkg::SQ_W-1:0]         mem_qa [MAX_FEATURES];
    logic [tst_pkg::SQ_W-1:0]         mem_qb [MAX_FEATURES];
    logic [MAX_FEATURES-1:0]          va_reg;
    logic [MAX_FEATURES-1:0]          vb_reg;

    logic signed [tst_pkg::SUM_W-1:0] rd_sa_reg;
    logic signed [tst_pkg::SUM_W-1:0] rd_sb_reg;
    logic [tst_pkg::SQ_W-1:0]         rd_qa_reg;
    logic [tst_pkg::SQ_W-1:0]         rd_qb_reg;
    logic                             rd_va_reg;
    logic                             rd_vb_reg;
    logic [47:0]                      sq_reg;

    logic [tst_pkg::IDX_W-1:0]        f_reg;
    logic [tst_pkg::CNT_W-1:0]        na_reg;
    logic [tst_pkg::CNT_W-1:0]        nb_reg;
    logic [tst_pkg::CNT_W:0]          n_reg;
    logic [18:0]                      nan_reg;
    logic [18:0]                      nbn_reg;
    logic signed [tst_pkg::SUM_W-1:0] sa_reg;
    logic signed [tst_pkg::SUM_W-1:0] sb_reg;
    logic [tst_pkg::SQ_W-1:0]         qa_reg;
    logic [tst_pkg::SQ_W-1:0]         qb_reg;
    logic [127:0]                     tmp_reg;
    logic [63:0]                      ta_reg;
    logic [63:0]                      tb_reg;
    logic [127:0]                     den_reg;
    logic signed [42:0]               pa_reg;
    logic [41:0]                      dmag_reg;

    logic [127:0] mul_a_reg;
    logic [63:0]  mul_b_reg;
    logic [127:0] mul_acc_reg;

    logic [127:0] rem_reg;
    logic [127:0] quo_reg;
    logic [127:0] numsh_reg;
    logic [6:0]   div_cnt_reg;

    logic [63:0] x_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;

    logic [tst_pkg::STAT_W-1:0] stat_reg;
    logic [tst_pkg::ERR_W-1:0]  err_reg;

    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    wr_addr;
    logic                             wr_a;
    logic                             wr_b;
    logic signed [tst_pkg::SUM_W-1:0] sum_next;
    logic [tst_pkg::SQ_W-1:0]         sq_next;
    logic [tst_pkg::CNT_W:0]          n_cmd;
    logic [31:0]                      abs_sa;
    logic [31:0]                      abs_sb;
    logic [127:0]                     den_next;
    logic                             ta_ge;
    logic [63:0]                      t_diff;
    logic signed [42:0]               prod_s;
    logic signed [42:0]               d_val;
    logic [128:0]                     r_shift;
    logic [128:0]                     r_sub;
    logic [63:0]                      root_bit;
    logic                             last;

    always_comb
    begin
        n_cmd    = {1'b0, cmd_reg.na} + {1'b0, cmd_reg.nb};
        rd_addr  = (state_reg == S_ACC_RD) ? cmd_reg.pos[AW-1:0] : f_reg[AW-1:0];
        wr_addr  = cmd_reg.pos[AW-1:0];
        wr_a     = (state_reg == S_ACC_WR) && !cmd_reg.grp;
        wr_b     = (state_reg == S_ACC_WR) && cmd_reg.grp;
        sum_next = (cmd_reg.grp ? (rd_vb_reg ? rd_sb_reg : '0) : (rd_va_reg ? rd_sa_reg : '0))
                   + tst_pkg::SUM_W'(cmd_reg.value);
        sq_next  = (cmd_reg.grp ? (rd_vb_reg ? rd_qb_reg : '0) : (rd_va_reg ? rd_qa_reg : '0))
                   + tst_pkg::SQ_W'(sq_reg);
        abs_sa   = sa_reg[31] ? 32'(-sa_reg) : 32'(sa_reg);
        abs_sb   = sb_reg[31] ? 32'(-sb_reg) : 32'(sb_reg);
        den_next = den_reg + mul_acc_reg;
        ta_ge    = tmp_reg[64:0] >= {1'b0, mul_acc_reg[63:0]};
        t_diff   = tmp_reg[63:0] - mul_acc_reg[63:0];
        if ((op_reg == OP_SANB) ? sa_reg[31] : sb_reg[31])
        begin
            prod_s = -$signed({1'b0, mul_acc_reg[41:0]});
        end
        else
        begin
            prod_s = $signed({1'b0, mul_acc_reg[41:0]});
        end
        d_val    = pa_reg - prod_s;
        r_shift  = {rem_reg, numsh_reg[127]};
        r_sub    = r_shift - {1'b0, den_reg};
        root_bit = root_reg + bit_reg;
        last     = ({1'b0, f_reg} == (cmd_reg.fc - 1'b1));
        cmd_pop  = (state_reg == S_IDLE) && !cmd_empty;
        res_push = (state_reg == S_EMIT) && !res_full;
        res.feature_index = f_reg;
        res.statistic     = stat_reg;
        res.error_code    = err_reg;
        res.last_feature  = last;
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_sa[wr_addr] <= sum_next;
            mem_qa[wr_addr] <= sq_next;
        end
        if (wr_b)
        begin
            mem_sb[wr_addr] <= sum_next;
            mem_qb[wr_addr] <= sq_next;
        end
        rd_sa_reg <= mem_sa[rd_addr];
        rd_sb_reg <= mem_sb[rd_addr];
        rd_qa_reg <= mem_qa[rd_addr];
        rd_qb_reg <= mem_qb[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NAQA;
            va_reg    <= '0;
            vb_reg    <= '0;
            rd_va_reg <= 1'b0;
            rd_vb_reg <= 1'b0;
        end
        else
        begin
            rd_va_reg <= va_reg[rd_addr];
            rd_vb_reg <= vb_reg[rd_addr];
            case (state_reg)
                S_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cmd_reg <= cmd;
                        if (cmd.do_acc)
                        begin
                            state_reg <= S_ACC_RD;
                        end
                        else if (cmd.is_end)
                        begin
                            state_reg <= S_EV_START;
                        end
                    end
                end
                S_ACC_RD:
                begin
                    sq_reg    <= 48'(cmd_reg.value * cmd_reg.value);
                    state_reg <= S_ACC_WR;
                end
                S_ACC_WR:
                begin
                    if (cmd_reg.grp)
                    begin
                        vb_reg[wr_addr] <= 1'b1;
                    end
                    else
                    begin
                        va_reg[wr_addr] <= 1'b1;
                    end
                    state_reg <= cmd_reg.is_end ? S_EV_START : S_IDLE;
                end
                S_EV_START:
                begin
                    f_reg     <= '0;
                    na_reg    <= cmd_reg.na;
                    nb_reg    <= cmd_reg.nb;
                    n_reg     <= n_cmd;
                    nan_reg   <= 19'(cmd_reg.na * n_cmd);
                    nbn_reg   <= 19'(cmd_reg.nb * n_cmd);
                    state_reg <= S_EV_RD;
                end
                S_EV_RD:
                begin
                    state_reg <= S_EV_LOAD;
                end
                S_EV_LOAD:
                begin
                    sa_reg   <= rd_va_reg ? rd_sa_reg : '0;
                    qa_reg   <= rd_va_reg ? rd_qa_reg : '0;
                    sb_reg   <= rd_vb_reg ? rd_sb_reg : '0;
                    qb_reg   <= rd_vb_reg ? rd_qb_reg : '0;
                    stat_reg <= '0;
                    op_reg   <= OP_NAQA;
                    if (cmd_reg.ovf)
                    begin
                        err_reg   <= tst_pkg::ERR_OVF;
                        state_reg <= S_EMIT;
                    end
                    else if (na_reg == '0 || nb_reg == '0 || n_reg < 10'd3)
                    begin
                        err_reg   <= tst_pkg::ERR_FEW;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        err_reg   <= tst_pkg::ERR_OK;
                        state_reg <= S_MUL_LOAD;
                    end
                end
                S_MUL_LOAD:
                begin
                    mul_acc_reg <= '0;
                    case (op_reg)
                        OP_NAQA:
                        begin
                            mul_a_reg <= 128'(qa_reg);
                            mul_b_reg <= 64'(na_reg);
                        end
                        OP_SASQ:
                        begin
                            mul_a_reg <= 128'(abs_sa);
                            mul_b_reg <= 64'(abs_sa);
                        end
                        OP_NBQB:
                        begin
                            mul_a_reg <= 128'(qb_reg);
                            mul_b_reg <= 64'(nb_reg);
                        end
                        OP_SBSQ:
                        begin
                            mul_a_reg <= 128'(abs_sb);
                            mul_b_reg <= 64'(abs_sb);
                        end
                        OP_TAN:
                        begin
                            mul_a_reg <= 128'(ta_reg);
                            mul_b_reg <= 64'(nbn_reg);
                        end
                        OP_TBN:
                        begin
                            mul_a_reg <= 128'(tb_reg);
                            mul_b_reg <= 64'(nan_reg);
                        end
                        OP_SANB:
                        begin
                            mul_a_reg <= 128'(abs_sa);
                            mul_b_reg <= 64'(nb_reg);
                        end
                        OP_SBNA:
                        begin
                            mul_a_reg <= 128'(abs_sb);
                            mul_b_reg <= 64'(na_reg);
                        end
                        OP_DSQ:
                        begin
                            mul_a_reg <= 128'(dmag_reg);
                            mul_b_reg <= 64'(dmag_reg);
                        end
                        default:
                        begin
                            mul_a_reg <= tmp_reg;
                            mul_b_reg <= 64'(n_reg - 10'd2);
                        end
                    endcase
                    state_reg <= S_MUL_RUN;
                end
                S_MUL_RUN:
                begin
                    if (mul_b_reg == '0)
                    begin
                        state_reg <= S_MUL_DONE;
                    end
                    else
                    begin
                        if (mul_b_reg[0])
                        begin
                            mul_acc_reg <= mul_acc_reg + mul_a_reg;
                        end
                        mul_a_reg <= {mul_a_reg[126:0], 1'b0};
                        mul_b_reg <= {1'b0, mul_b_reg[63:1]};
                    end
                end
                S_MUL_DONE:
                begin
                    state_reg <= S_MUL_LOAD;
                    case (op_reg)
                        OP_NAQA:
                        begin
                            tmp_reg <= mul_acc_reg;
                            op_reg  <= OP_SASQ;
                        end
                        OP_SASQ:
                        begin
                            ta_reg <= ta_ge ? t_diff : '0;
                            op_reg <= OP_NBQB;
                        end
                        OP_NBQB:
                        begin
                            tmp_reg <= mul_acc_reg;
                            op_reg  <= OP_SBSQ;
                        end
                        OP_SBSQ:
                        begin
                            tb_reg <= ta_ge ? t_diff : '0;
                            op_reg <= OP_TAN;
                        end
                        OP_TAN:
                        begin
                            den_reg <= mul_acc_reg;
                            op_reg  <= OP_TBN;
                        end
                        OP_TBN:
                        begin
                            den_reg <= den_next;
                            op_reg  <= OP_SANB;
                            if (den_next == '0)
                            begin
                                err_reg   <= tst_pkg::ERR_ZERO;
                                state_reg <= S_EMIT;
                            end
                        end
                        OP_SANB:
                        begin
                            pa_reg <= prod_s;
                            op_reg <= OP_SBNA;
                        end
                        OP_SBNA:
                        begin
                            dmag_reg <= d_val[42] ? 42'(-d_val) : 42'(d_val);
                            op_reg   <= OP_DSQ;
                        end
                        OP_DSQ:
                        begin
                            tmp_reg <= mul_acc_reg;
                            op_reg  <= OP_DN;
                        end
                        default:
                        begin
                            numsh_reg   <= {mul_acc_reg[95:0], 32'd0};
                            rem_reg     <= '0;
                            quo_reg     <= '0;
                            div_cnt_reg <= 7'd127;
                            state_reg   <= S_DIV;
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (!r_sub[128])
                    begin
                        rem_reg <= r_sub[127:0];
                        quo_reg <= {quo_reg[126:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= r_shift[127:0];
                        quo_reg <= {quo_reg[126:0], 1'b0};
                    end
                    numsh_reg   <= {numsh_reg[126:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= S_SQRT_INIT;
                    end
                end
                S_SQRT_INIT:
                begin
                    if (quo_reg[127:64] != '0)
                    begin
                        stat_reg  <= '1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        x_reg     <= quo_reg[63:0];
                        root_reg  <= '0;
                        bit_reg   <= 64'd1 << 62;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        stat_reg  <= root_reg[31:0];
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        if (x_reg >= root_bit)
                        begin
                            x_reg    <= x_reg - root_bit;
                            root_reg <= {1'b0, root_reg[63:1]} + bit_reg;
                        end
                        else
                        begin
                            root_reg <= {1'b0, root_reg[63:1]};
                        end
                        bit_reg <= {2'b00, bit_reg[63:2]};
                    end
                end
                S_EMIT:
                begin
                    if (!res_full)
                    begin
                        if (last)
                        begin
                            va_reg    <= '0;
                            vb_reg    <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            f_reg     <= f_reg + 1'b1;
                            state_reg <= S_EV_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/two_sample_t_statistic.sv -----
// A value leaving the command queue is registered, read from its sums in S_ACC_RD and
// written back in S_ACC_WR; the next item is taken only after that write-back.
// An end-of-data item evaluates each feature in turn: up to ten shift-add
// multiplies (one multiplier bit per cycle), a 128-bit restoring divide, a 64-bit root.
// Input stalls whenever the 4-entry command queue is full, as it fills while evaluation runs.
// Reset clears all stores at once through per-entry valid bits; no sweep.
// ----------------------------------------------------------------------------
// two_sample_t_statistic: pooled-variance two-sample t statistic
// Accumulates per-feature group sums and emits one Q16.16 statistic per
// feature on end of data.
// ----------------------------------------------------------------------------
module two_sample_t_statistic #(
    parameter int MAX_FEATURES = tst_pkg::MAX_FEATURES_DEF,
    parameter int MAX_SUBJECTS = tst_pkg::MAX_SUBJECTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tst_pkg::FC_W-1:0]         cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic                             group,
    input  logic signed [tst_pkg::VAL_W-1:0] value,
    input  logic                             end_of_data,
    input  logic                             pop,
    output logic                             empty,
    output logic [tst_pkg::IDX_W-1:0]        feature_index,
    output logic [tst_pkg::STAT_W-1:0]       statistic,
    output logic [tst_pkg::ERR_W-1:0]        error_code,
    output logic                             last_feature
);

    tst_pkg::cmd_t cmd_in;
    tst_pkg::cmd_t cmd_out;
    tst_pkg::res_t res_in;
    tst_pkg::res_t res_out;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;
    logic          res_push;
    logic          res_full;

    tst_front #(
        .MAX_FEATURES(MAX_FEATURES),
        .MAX_SUBJECTS(MAX_SUBJECTS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .group(group),
        .value(value),
        .end_of_data(end_of_data),
        .cmd_push(cmd_push),
        .cmd_full(cmd_full),
        .cmd(cmd_in)
    );

    tst_fifo #(
        .WIDTH($bits(tst_pkg::cmd_t)),
        .DEPTH_LOG2(tst_pkg::CMD_QUEUE_LOG2)
    ) u_cmd_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(cmd_push),
        .data_in(cmd_in),
        .full(cmd_full),
        .pop(cmd_pop),
        .data_out(cmd_out),
        .empty(cmd_empty)
    );

    tst_back #(
        .MAX_FEATURES(MAX_FEATURES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_empty(cmd_empty),
        .cmd(cmd_out),
        .cmd_pop(cmd_pop),
        .res_full(res_full),
        .res_push(res_push),
        .res(res_in)
    );

    tst_fifo #(
        .WIDTH($bits(tst_pkg::res_t)),
        .DEPTH_LOG2(tst_pkg::RES_QUEUE_LOG2)
    ) u_res_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(res_push),
        .data_in(res_in),
        .full(res_full),
        .pop(pop),
        .data_out(res_out),
        .empty(empty)
    );

    assign feature_index = res_out.feature_index;
    assign statistic     = res_out.statistic;
    assign error_code    = res_out.error_code;
    assign last_feature  = res_out.last_feature;

    a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into full queue");

    a_cmd_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command written into full queue");

    a_err_zero_stat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_code != tst_pkg::ERR_OK) |-> (statistic == '0))
        else $error("error result carries nonzero statistic");

endmodule
